// File: rtl/npd_pkg.sv
// Shared types and constants for the number partition differencing block.
// No dependencies; every other file imports this package.
package npd_pkg;

   localparam int SLOT_BITS  = 47;
   localparam int GROUP_BITS = 7;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [SLOT_BITS-1:0] SLOT_MAX = '1;

   // Register index of the mode bit in the configuration space.
   localparam logic CSR_IDX_GROUPED_MODE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SCAN,
      ST_DIFF_HI,
      ST_DIFF_LO,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD_SAT,
      ALU_SUB
   } alu_op_type;

endpackage

// File: rtl/npd_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on npd_pkg for the fixed field widths.
interface npd_req_if import npd_pkg::*; #(parameter int VALUE_BITS = 40) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [GROUP_BITS-1:0] group;
   logic                  last;

   modport source (output valid, value, group, last, input ready);
   modport sink   (input valid, value, group, last, output ready);
endinterface

interface npd_rsp_if import npd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_BITS-1:0] residue;
   logic                 overflowed;

   modport source (output valid, residue, overflowed, input ready);
   modport sink   (input valid, residue, overflowed, output ready);
endinterface

// File: rtl/number_partition_differencing_top.sv
// Sequence: a request without last passes accept, slot read and slot write.
// A request with last then runs R rounds (a scan, then the two differencing writes), one final
// scan and a done step, where R is at most the number of nonzero slots minus one; one
// slot-store pass per round is the limit. A clear pass over the store follows.
// Reset: the store is cleared by the same pass (req ready held low).
// Depends on npd_pkg, npd_if and npd_alu.
module number_partition_differencing_top import npd_pkg::*; #(
   parameter int SLOT_COUNT = 128,
   parameter int VALUE_BITS = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   npd_req_if.sink                  req_chan,
   npd_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_BITS = $clog2(SLOT_COUNT + 1);
   localparam int GRP_EXT  = (CNT_BITS > GROUP_BITS) ? CNT_BITS : GROUP_BITS;
   localparam int OPB_BITS = (VALUE_BITS > SLOT_BITS) ? VALUE_BITS : SLOT_BITS;

   state_type state_ff, state_in;

   logic                  grouped_mode_ff, grouped_mode_in;
   logic [CNT_BITS-1:0]   fill_count_ff, fill_count_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]   idx_cnt_ff, idx_cnt_in;
   logic                  proc_vld_ff, proc_vld_in;
   logic [IDX_BITS-1:0]   proc_idx_ff, proc_idx_in;

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [IDX_BITS-1:0]   addr_ff, addr_in;
   logic                  drop_ff, drop_in;
   logic                  last_ff, last_in;

   logic                  have_hi_ff, have_hi_in;
   logic                  have_lo_ff, have_lo_in;
   logic [SLOT_BITS-1:0]  hv_ff, hv_in;
   logic [SLOT_BITS-1:0]  lv_ff, lv_in;
   logic [IDX_BITS-1:0]   hi_ff, hi_in;
   logic [IDX_BITS-1:0]   lo_ff, lo_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0]  residue_ff, residue_in;
   logic                  overflowed_ff, overflowed_in;

   logic [SLOT_BITS-1:0]  mem [SLOT_COUNT];
   logic [SLOT_BITS-1:0]  rd_data_ff;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [SLOT_BITS-1:0]  wr_data;

   alu_op_type            alu_op;
   logic [SLOT_BITS-1:0]  alu_a;
   logic [OPB_BITS-1:0]   alu_b;
   logic [SLOT_BITS-1:0]  alu_res;
   logic                  alu_gt;

   logic                  req_accept;
   logic [GRP_EXT-1:0]    grp_ext;
   logic                  csr_write;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      grouped_mode_in = grouped_mode_ff;
      if (csr_write && (paddr[2] == CSR_IDX_GROUPED_MODE)) begin
         grouped_mode_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_GROUPED_MODE) begin
         prdata = CSR_DATA_BITS'(grouped_mode_ff);
      end
   end

   // ---------------- slot store ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------- shared arithmetic unit ----------------
   always_comb begin
      alu_op = ALU_ADD_SAT;
      alu_a  = rd_data_ff;
      alu_b  = OPB_BITS'(hv_ff);
      case (state_ff)
         ST_LOAD_WR: begin
            alu_b = OPB_BITS'(value_ff);
         end
         ST_DIFF_HI: begin
            alu_op = ALU_SUB;
            alu_a  = hv_ff;
            alu_b  = OPB_BITS'(lv_ff);
         end
         default: begin
         end
      endcase
   end

   npd_alu #(
      .OPB_BITS (OPB_BITS)
   ) u_alu (
      .op  (alu_op),
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_res),
      .gt  (alu_gt)
   );

   // ---------------- sequencer ----------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign grp_ext        = GRP_EXT'(req_chan.group);

   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      ovf_in        = ovf_ff;
      idx_cnt_in    = idx_cnt_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      value_in      = value_ff;
      addr_in       = addr_ff;
      drop_in       = drop_ff;
      last_in       = last_ff;
      have_hi_in    = have_hi_ff;
      have_lo_in    = have_lo_ff;
      hv_in         = hv_ff;
      lv_in         = lv_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      residue_in    = residue_ff;
      overflowed_in = overflowed_ff;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = alu_res;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = idx_cnt_ff[IDX_BITS-1:0];
            wr_data    = '0;
            idx_cnt_in = idx_cnt_ff + 1'b1;
            if (idx_cnt_ff == CNT_BITS'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               value_in = req_chan.value;
               last_in  = req_chan.last;
               drop_in  = 1'b0;
               if (grouped_mode_ff) begin
                  addr_in = grp_ext[IDX_BITS-1:0];
                  if (grp_ext >= GRP_EXT'(SLOT_COUNT)) begin
                     drop_in = 1'b1;
                     ovf_in  = 1'b1;
                  end
               end else begin
                  addr_in = fill_count_ff[IDX_BITS-1:0];
                  if (fill_count_ff < CNT_BITS'(SLOT_COUNT)) begin
                     fill_count_in = fill_count_ff + 1'b1;
                  end else begin
                     drop_in = 1'b1;
                     ovf_in  = 1'b1;
                  end
               end
               state_in = ST_LOAD_RD;
            end
         end
         ST_LOAD_RD: begin
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            wr_en = !drop_ff;
            if (last_ff) begin
               idx_cnt_in = '0;
               have_hi_in = 1'b0;
               have_lo_in = 1'b0;
               hv_in      = '0;
               lv_in      = '0;
               state_in   = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Reads are issued in the cycle before the compare on the returned data.
            if (idx_cnt_ff < CNT_BITS'(SLOT_COUNT)) begin
               rd_addr     = idx_cnt_ff[IDX_BITS-1:0];
               proc_vld_in = 1'b1;
               proc_idx_in = idx_cnt_ff[IDX_BITS-1:0];
               idx_cnt_in  = idx_cnt_ff + 1'b1;
            end
            if (proc_vld_ff) begin
               if (!have_hi_ff || alu_gt) begin
                  if (have_hi_ff) begin
                     lo_in      = hi_ff;
                     lv_in      = hv_ff;
                     have_lo_in = 1'b1;
                  end
                  hi_in      = proc_idx_ff;
                  hv_in      = rd_data_ff;
                  have_hi_in = 1'b1;
               end else if (!have_lo_ff || (rd_data_ff > lv_ff)) begin
                  lo_in      = proc_idx_ff;
                  lv_in      = rd_data_ff;
                  have_lo_in = 1'b1;
               end
            end else if (idx_cnt_ff == CNT_BITS'(SLOT_COUNT)) begin
               // Every round removes a nonzero slot, so this exit is always reached.
               if (!have_lo_ff || (lv_ff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIFF_HI;
               end
            end
         end
         ST_DIFF_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            state_in = ST_DIFF_LO;
         end
         ST_DIFF_LO: begin
            wr_en      = 1'b1;
            wr_addr    = lo_ff;
            wr_data    = '0;
            idx_cnt_in = '0;
            have_hi_in = 1'b0;
            have_lo_in = 1'b0;
            hv_in      = '0;
            lv_in      = '0;
            state_in   = ST_SCAN;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               residue_in    = hv_ff;
               overflowed_in = ovf_ff;
               fill_count_in = '0;
               ovf_in        = 1'b0;
               idx_cnt_in    = '0;
               state_in      = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         grouped_mode_ff <= 1'b0;
         fill_count_ff   <= '0;
         ovf_ff          <= 1'b0;
         idx_cnt_ff      <= '0;
         proc_vld_ff     <= 1'b0;
         have_hi_ff      <= 1'b0;
         have_lo_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         grouped_mode_ff <= grouped_mode_in;
         fill_count_ff   <= fill_count_in;
         ovf_ff          <= ovf_in;
         idx_cnt_ff      <= idx_cnt_in;
         proc_vld_ff     <= proc_vld_in;
         have_hi_ff      <= have_hi_in;
         have_lo_ff      <= have_lo_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff   <= proc_idx_in;
      value_ff      <= value_in;
      addr_ff       <= addr_in;
      drop_ff       <= drop_in;
      last_ff       <= last_in;
      hv_ff         <= hv_in;
      lv_ff         <= lv_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      residue_ff    <= residue_in;
      overflowed_ff <= overflowed_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.residue    = residue_ff;
   assign rsp_chan.overflowed = overflowed_ff;

   // ---------------- assertions ----------------
   a_diff_distinct_slots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF_HI) |-> (hi_ff != lo_ff) && have_hi_ff && have_lo_ff)
      else $error("differencing round picked the same slot twice");

   a_diff_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF_HI) |-> (hv_ff >= lv_ff) && (lv_ff != '0))
      else $error("second largest exceeds largest or is zero");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_BITS'(SLOT_COUNT))
      else $error("fill count ran past the slot count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done step");

   a_round_restarts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF_LO) |=> (state_ff == ST_SCAN) && (idx_cnt_ff == '0) && !proc_vld_ff)
      else $error("new round did not restart the scan");

endmodule

// File: rtl/npd_alu.sv
// Shared arithmetic unit: saturating add, subtract and greater-than compare.
// Depends on npd_pkg; used by number_partition_differencing_top.
module npd_alu import npd_pkg::*; #(
   parameter int OPB_BITS = 48
) (
   input  alu_op_type           op,
   input  logic [SLOT_BITS-1:0] opa,
   input  logic [OPB_BITS-1:0]  opb,
   output logic [SLOT_BITS-1:0] res,
   output logic                 gt
);

   localparam int W = OPB_BITS + 1;

   logic [W-1:0] a_ext;
   logic [W-1:0] b_ext;
   logic [W-1:0] sum;
   logic [W-1:0] diff;

   assign a_ext = W'(opa);
   assign b_ext = W'(opb);
   assign sum   = a_ext + b_ext;
   assign diff  = a_ext - b_ext;

   // Both operands sit below the top bit, so the top bit of the difference is the borrow.
   assign gt = !diff[W-1] && (diff != '0);

   always_comb begin
      case (op)
         ALU_ADD_SAT: res = (sum > W'(SLOT_MAX)) ? SLOT_MAX : sum[SLOT_BITS-1:0];
         ALU_SUB:     res = diff[SLOT_BITS-1:0];
         default:     res = '0;
      endcase
   end

endmodule
